>>> rtl/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Sizes, link encoding, opcodes, status codes and the request beat type.
// ---------------------------------------------------------------------------
package chm_pkg;

    // Table sizes; BUCKETS must be a power of two (bucket is the low key bits)
    localparam int BUCKETS  = 64;
    localparam int ENTRIES  = 256;
    localparam int KEY_BITS = 32;
    localparam int VAL_BITS = 32;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int LINK_W = $clog2(ENTRIES + 1);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // The null link is the value ENTRIES
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ENTRIES);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Classified request beat passed from front to back
    typedef struct packed {
        op_t                 op;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] value;
        logic [BKT_W-1:0]    bkt;
    } req_t;

endpackage

>>> rtl/chm_ram.sv
// ---------------------------------------------------------------------------
// chm_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/chm_front.sv
// ---------------------------------------------------------------------------
// chm_front: request intake and queue
// Takes command beats, works out the bucket and holds them in a short FIFO.
// ---------------------------------------------------------------------------
module chm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    opcode,
    input  logic [31:0]                   key,
    input  logic [31:0]                   value,
    output logic                          q_valid,
    output chm_pkg::req_t                 q_req,
    input  logic                          q_pop
);
    import chm_pkg::*;

    req_t               fifo_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               push;
    logic               pop;
    req_t               new_req;

    // Classify the incoming beat
    always_comb
    begin
        new_req.op    = op_t'(opcode);
        new_req.key   = KEY_BITS'(key);
        new_req.value = VAL_BITS'(value);
        new_req.bkt   = key[BKT_W-1:0];
    end

    assign busy    = (cnt_reg == QCNT_W'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_req   = fifo_reg[rd_ptr_reg];

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

>>> rtl/chm_back.sv
// ---------------------------------------------------------------------------
// chm_back: table engine
// Walks bucket chains through the entry RAMs, then updates, unlinks or
// answers, and drives the result strobe.
// ---------------------------------------------------------------------------
module chm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  chm_pkg::req_t q_req,
    output logic          q_pop,
    output logic          done,
    output logic [1:0]    status,
    output logic          found,
    output logic [31:0]   value_out,
    output logic [8:0]    count
);
    import chm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_HEAD = 6'b000010,
        S_WALK = 6'b000100,
        S_ACT  = 6'b001000,
        S_FREE = 6'b010000,
        S_REM  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [BUCKETS-1:0]  hvalid_reg, hvalid_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]   hlink_reg, hlink_next;
    logic                hit_reg, hit_next;
    logic [VAL_BITS-1:0] hval_reg, hval_next;
    logic [LINK_W-1:0]   free_reg, free_next;
    logic [LINK_W-1:0]   fresh_reg, fresh_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic                found_reg, found_next;
    logic [VAL_BITS-1:0] vout_reg, vout_next;

    // RAM ports
    logic [ADDR_W-1:0]   e_raddr;
    logic [KEY_BITS-1:0] key_rd;
    logic [VAL_BITS-1:0] val_rd;
    logic [LINK_W-1:0]   link_rd;
    logic                key_we, val_we, link_we;
    logic [ADDR_W-1:0]   key_waddr, val_waddr, link_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic [VAL_BITS-1:0] val_wdata;
    logic [LINK_W-1:0]   link_wdata;
    logic [BKT_W-1:0]    h_raddr;
    logic                h_we;
    logic [BKT_W-1:0]    h_waddr;
    logic [LINK_W-1:0]   h_wdata;
    logic [LINK_W-1:0]   h_rd;
    logic [LINK_W-1:0]   head_cur;
    logic [LINK_W-1:0]   new_e;

    chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(e_raddr), .rdata(key_rd)
    );

    chm_ram #(.WIDTH(VAL_BITS), .DEPTH(ENTRIES)) u_val_ram (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(e_raddr), .rdata(val_rd)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_link_ram (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(e_raddr), .rdata(link_rd)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head_ram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rd)
    );

    // Bucket head as seen after the valid bits
    assign head_cur = hvalid_reg[req_reg.bkt] ? h_rd : NULL_LINK;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        hvalid_next = hvalid_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        hlink_next  = hlink_reg;
        hit_next    = hit_reg;
        hval_next   = hval_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        vout_next   = vout_reg;
        q_pop       = 1'b0;
        e_raddr     = cur_reg[ADDR_W-1:0];
        h_raddr     = req_reg.bkt;
        key_we      = 1'b0;
        val_we      = 1'b0;
        link_we     = 1'b0;
        h_we        = 1'b0;
        key_waddr   = cur_reg[ADDR_W-1:0];
        val_waddr   = cur_reg[ADDR_W-1:0];
        link_waddr  = cur_reg[ADDR_W-1:0];
        key_wdata   = req_reg.key;
        val_wdata   = req_reg.value;
        link_wdata  = head_reg;
        h_waddr     = req_reg.bkt;
        h_wdata     = head_reg;
        new_e       = fresh_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    req_next = q_req;
                    h_raddr  = q_req.bkt;
                    if (q_req.op == OP_CLEAR)
                    begin
                        hvalid_next = '0;
                        free_next   = NULL_LINK;
                        fresh_next  = '0;
                        cnt_next    = '0;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        found_next  = 1'b0;
                        vout_next   = '0;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end

            S_HEAD:
            begin
                head_next = head_cur;
                cur_next  = head_cur;
                prev_next = NULL_LINK;
                hit_next  = 1'b0;
                e_raddr   = head_cur[ADDR_W-1:0];
                state_next = (head_cur == NULL_LINK) ? S_ACT : S_WALK;
            end

            // One chain entry per cycle
            S_WALK:
            begin
                if (key_rd == req_reg.key)
                begin
                    hit_next   = 1'b1;
                    hlink_next = link_rd;
                    hval_next  = val_rd;
                    state_next = S_ACT;
                end
                else if (link_rd == NULL_LINK)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    e_raddr   = link_rd[ADDR_W-1:0];
                end
            end

            S_ACT:
            begin
                status_next = ST_OK;
                found_next  = hit_reg;
                vout_next   = '0;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                case (req_reg.op)
                    OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            val_we = 1'b1;
                        end
                        else if (free_reg != NULL_LINK)
                        begin
                            e_raddr    = free_reg[ADDR_W-1:0];
                            done_next  = 1'b0;
                            state_next = S_FREE;
                        end
                        else if (fresh_reg < LINK_W'(ENTRIES))
                        begin
                            new_e      = fresh_reg;
                            fresh_next = LINK_W'(fresh_reg + 1'b1);
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            link_we    = 1'b1;
                            h_we       = 1'b1;
                            key_waddr  = new_e[ADDR_W-1:0];
                            val_waddr  = new_e[ADDR_W-1:0];
                            link_waddr = new_e[ADDR_W-1:0];
                            h_wdata    = new_e;
                            hvalid_next[req_reg.bkt] = 1'b1;
                            cnt_next   = CNT_W'(cnt_reg + 1'b1);
                            found_next = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            if (prev_reg == NULL_LINK)
                            begin
                                h_we    = 1'b1;
                                h_wdata = hlink_reg;
                            end
                            else
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg[ADDR_W-1:0];
                                link_wdata = hlink_reg;
                            end
                            done_next  = 1'b0;
                            state_next = S_REM;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            vout_next = hval_reg;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b0;
                    end
                endcase
            end

            // Reuse a freed entry: its link gives the new free head
            S_FREE:
            begin
                new_e      = free_reg;
                free_next  = link_rd;
                key_we     = 1'b1;
                val_we     = 1'b1;
                link_we    = 1'b1;
                h_we       = 1'b1;
                key_waddr  = new_e[ADDR_W-1:0];
                val_waddr  = new_e[ADDR_W-1:0];
                link_waddr = new_e[ADDR_W-1:0];
                h_wdata    = new_e;
                hvalid_next[req_reg.bkt] = 1'b1;
                cnt_next    = CNT_W'(cnt_reg + 1'b1);
                done_next   = 1'b1;
                status_next = ST_OK;
                found_next  = 1'b0;
                vout_next   = '0;
                state_next  = S_IDLE;
            end

            // Push the removed entry onto the free list
            S_REM:
            begin
                link_we     = 1'b1;
                link_waddr  = cur_reg[ADDR_W-1:0];
                link_wdata  = free_reg;
                free_next   = cur_reg;
                if (cnt_reg != '0)
                begin
                    cnt_next = CNT_W'(cnt_reg - 1'b1);
                end
                done_next   = 1'b1;
                status_next = ST_OK;
                found_next  = 1'b1;
                vout_next   = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hvalid_reg <= '0;
            free_reg   <= NULL_LINK;
            fresh_reg  <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hvalid_reg <= hvalid_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        hlink_reg  <= hlink_next;
        hit_reg    <= hit_next;
        hval_reg   <= hval_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        vout_reg   <= vout_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign value_out = 32'(vout_reg);
    assign count     = 9'(cnt_reg);

endmodule

>>> rtl/chained_hash_map.sv
// ---------------------------------------------------------------------------
// chained_hash_map: fixed-capacity key/value table with separate chaining
// A request passes S_IDLE, S_HEAD, S_WALK (once per chain entry compared)
// and S_ACT, plus S_REM on a remove hit or S_FREE on an insert that reuses
// a freed entry; a clear is answered from S_IDLE. One request is in the
// engine at a time, taken in S_IDLE, with a 2-beat queue in front. Results
// cannot be stalled. Reset empties the table at once.
// ---------------------------------------------------------------------------
module chained_hash_map (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        done,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] value_out,
    output logic [8:0]  count
);
    import chm_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;

    // Intake and queue
    chm_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .key(key), .value(value),
        .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
    );

    // Table engine
    chm_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_pop(q_pop), .done(done), .status(status), .found(found),
        .value_out(value_out), .count(count)
    );

endmodule
